FILE: design/rotation_matrix_to_quaternion_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotation matrix to quaternion block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RMQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmq port check failed");

// Next-cycle implication, disabled during reset.
`define RMQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmq port check failed");

`endif

FILE: design/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Constants and pipeline types shared by the matrix to quaternion cells.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  localparam int DW        = 16;
  localparam int T_W       = DW + 2;
  localparam int ARG_W     = DW + 3;
  localparam int SQ_STEPS  = 15;
  localparam int RAD_W     = 2 * SQ_STEPS;
  localparam int SQREM_W   = SQ_STEPS + 3;
  localparam int MAG_W     = DW + 1;
  localparam int FRAC_SH   = 12;
  localparam int NUM_W     = MAG_W + FRAC_SH;
  localparam int DIV_STEPS = NUM_W;
  localparam int DVREM_W   = SQ_STEPS + 1;
  localparam int LANES     = 3;
  localparam int LATENCY   = SQ_STEPS + DIV_STEPS + 2;
  localparam int FRAC_ONE  = 16384;

  localparam logic [1:0] SEL_W = 2'd0;
  localparam logic [1:0] SEL_X = 2'd1;
  localparam logic [1:0] SEL_Y = 2'd2;
  localparam logic [1:0] SEL_Z = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] sel;
    logic       degen;
  } rmq_ctl_t;

  typedef struct packed {
    rmq_ctl_t                         ctl;
    logic [RAD_W-1:0]                 rad;
    logic [SQREM_W-1:0]               rem;
    logic [SQ_STEPS-1:0]              root;
    logic [LANES-1:0][MAG_W-1:0]      mag;
    logic [LANES-1:0]                 neg;
  } rmq_sq_t;

  typedef struct packed {
    rmq_ctl_t                         ctl;
    logic [SQ_STEPS-1:0]              root;
    logic [LANES-1:0][NUM_W-1:0]      num;
    logic [LANES-1:0][DVREM_W-1:0]    rem;
    logic [LANES-1:0]                 neg;
  } rmq_dv_t;

endpackage

`default_nettype wire

FILE: design/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Forms the four diagonal candidates, picks the largest and prepares the
// root argument and the off-diagonal terms.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              req,
  input  wire logic signed [rmq_pkg::DW-1:0]     c0r0,
  input  wire logic signed [rmq_pkg::DW-1:0]     c0r1,
  input  wire logic signed [rmq_pkg::DW-1:0]     c0r2,
  input  wire logic signed [rmq_pkg::DW-1:0]     c1r0,
  input  wire logic signed [rmq_pkg::DW-1:0]     c1r1,
  input  wire logic signed [rmq_pkg::DW-1:0]     c1r2,
  input  wire logic signed [rmq_pkg::DW-1:0]     c2r0,
  input  wire logic signed [rmq_pkg::DW-1:0]     c2r1,
  input  wire logic signed [rmq_pkg::DW-1:0]     c2r2,
  output rmq_pkg::rmq_sq_t                       q
);

  logic signed [rmq_pkg::T_W-1:0]   a, e, i, tw, tx, ty, tz, best;
  logic signed [rmq_pkg::ARG_W-1:0] arg;
  logic signed [rmq_pkg::MAG_W-1:0] d [rmq_pkg::LANES];
  logic [1:0]                       sel;
  logic                             degen;
  rmq_pkg::rmq_sq_t                 q_r, q_nxt;

  function automatic logic signed [rmq_pkg::MAG_W-1:0] pair(
    input logic signed [rmq_pkg::DW-1:0] u,
    input logic signed [rmq_pkg::DW-1:0] v,
    input logic                          add
  );
    logic signed [rmq_pkg::MAG_W-1:0] su, sv;
    su = rmq_pkg::MAG_W'(u);
    sv = rmq_pkg::MAG_W'(v);
    return add ? su + sv : su - sv;
  endfunction

  always_comb begin
    a  = rmq_pkg::T_W'(c0r0);
    e  = rmq_pkg::T_W'(c1r1);
    i  = rmq_pkg::T_W'(c2r2);
    tw = a + e + i;
    tx = a - e - i;
    ty = e - a - i;
    tz = i - a - e;
    best = tw;
    sel  = rmq_pkg::SEL_W;
    if (tx > best) begin
      best = tx;
      sel  = rmq_pkg::SEL_X;
    end
    if (ty > best) begin
      best = ty;
      sel  = rmq_pkg::SEL_Y;
    end
    if (tz > best) begin
      best = tz;
      sel  = rmq_pkg::SEL_Z;
    end
    arg   = rmq_pkg::ARG_W'(best) + rmq_pkg::ARG_W'(rmq_pkg::FRAC_ONE);
    degen = arg[rmq_pkg::ARG_W-1] || (arg == '0);

    unique case (sel)
      rmq_pkg::SEL_W: begin
        d[0] = pair(c1r2, c2r1, 1'b0);
        d[1] = pair(c2r0, c0r2, 1'b0);
        d[2] = pair(c0r1, c1r0, 1'b0);
      end
      rmq_pkg::SEL_X: begin
        d[0] = pair(c1r2, c2r1, 1'b0);
        d[1] = pair(c0r1, c1r0, 1'b1);
        d[2] = pair(c2r0, c0r2, 1'b1);
      end
      rmq_pkg::SEL_Y: begin
        d[0] = pair(c2r0, c0r2, 1'b0);
        d[1] = pair(c0r1, c1r0, 1'b1);
        d[2] = pair(c1r2, c2r1, 1'b1);
      end
      default: begin
        d[0] = pair(c0r1, c1r0, 1'b0);
        d[1] = pair(c2r0, c0r2, 1'b1);
        d[2] = pair(c1r2, c2r1, 1'b1);
      end
    endcase

    q_nxt.ctl.valid = req;
    q_nxt.ctl.sel   = degen ? rmq_pkg::SEL_W : sel;
    q_nxt.ctl.degen = degen;
    q_nxt.rad       = degen ? '0 : {1'b0, arg[rmq_pkg::MAG_W-1:0],
                                    rmq_pkg::FRAC_SH'(0)};
    q_nxt.rem       = '0;
    q_nxt.root      = '0;
    for (int k = 0; k < rmq_pkg::LANES; k++) begin
      q_nxt.neg[k] = d[k][rmq_pkg::MAG_W-1];
      q_nxt.mag[k] = d[k][rmq_pkg::MAG_W-1] ? (~d[k] + 1'b1) : d[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.ctl.valid <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

FILE: design/rmq_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One digit of the restoring square root; passes the item to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  rmq_pkg::rmq_sq_t      d,
  output rmq_pkg::rmq_sq_t      q
);

  logic [rmq_pkg::SQREM_W-1:0] rem_sh, trial;
  logic                        ge;
  rmq_pkg::rmq_sq_t            q_r, q_nxt;

  always_comb begin
    rem_sh = {d.rem[rmq_pkg::SQREM_W-3:0], d.rad[rmq_pkg::RAD_W-1 -: 2]};
    trial  = {1'b0, d.root, 2'b01};
    ge     = rem_sh >= trial;
    q_nxt      = d;
    q_nxt.rem  = ge ? rem_sh - trial : rem_sh;
    q_nxt.root = {d.root[rmq_pkg::SQ_STEPS-2:0], ge};
    q_nxt.rad  = {d.rad[rmq_pkg::RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.ctl.valid <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

FILE: design/rmq_div_cell.sv
// ----------------------------------------------------------------------------
// rmq_div_cell
// One quotient bit of three restoring divisions by the root component.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  rmq_pkg::rmq_dv_t      d,
  output rmq_pkg::rmq_dv_t      q
);

  logic [rmq_pkg::DVREM_W:0] rem_sh [rmq_pkg::LANES];
  logic [rmq_pkg::DVREM_W:0] dvs;
  logic [rmq_pkg::LANES-1:0] ge;
  rmq_pkg::rmq_dv_t          q_r, q_nxt;

  always_comb begin
    dvs   = {2'b00, d.root};
    q_nxt = d;
    for (int k = 0; k < rmq_pkg::LANES; k++) begin
      rem_sh[k] = {d.rem[k], d.num[k][rmq_pkg::NUM_W-1]};
      ge[k]     = rem_sh[k] >= dvs;
      q_nxt.rem[k] = ge[k] ? rmq_pkg::DVREM_W'(rem_sh[k] - dvs)
                           : rmq_pkg::DVREM_W'(rem_sh[k]);
      q_nxt.num[k] = {d.num[k][rmq_pkg::NUM_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.ctl.valid <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

FILE: design/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a Q2.14 rotation matrix to a Q2.14 quaternion by Shepperd's method.
// ----------------------------------------------------------------------------
// A request is taken in every cycle in which start is high; busy is always
// low. Each result appears on the out_ ports for one cycle with out_valid
// high, and the receiver cannot stall it. The path is one front stage, a
// chain of 15 square-root cells (one root bit each), a chain of 29 division
// cells (one quotient bit for three lanes each) and one output register. A
// root argument that is not positive gives zeros and out_degenerate.
`default_nettype none

module rotation_matrix_to_quaternion (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic signed [rmq_pkg::DW-1:0]     in_c0r0,
  input  wire logic signed [rmq_pkg::DW-1:0]     in_c0r1,
  input  wire logic signed [rmq_pkg::DW-1:0]     in_c0r2,
  input  wire logic signed [rmq_pkg::DW-1:0]     in_c1r0,
  input  wire logic signed [rmq_pkg::DW-1:0]     in_c1r1,
  input  wire logic signed [rmq_pkg::DW-1:0]     in_c1r2,
  input  wire logic signed [rmq_pkg::DW-1:0]     in_c2r0,
  input  wire logic signed [rmq_pkg::DW-1:0]     in_c2r1,
  input  wire logic signed [rmq_pkg::DW-1:0]     in_c2r2,
  output      logic                              out_valid,
  output      logic signed [rmq_pkg::DW-1:0]     out_qw,
  output      logic signed [rmq_pkg::DW-1:0]     out_qx,
  output      logic signed [rmq_pkg::DW-1:0]     out_qy,
  output      logic signed [rmq_pkg::DW-1:0]     out_qz,
  output      logic [1:0]                        out_largest_sel,
  output      logic                              out_degenerate
);

  rmq_pkg::rmq_sq_t sq [rmq_pkg::SQ_STEPS+1];
  rmq_pkg::rmq_dv_t dv [rmq_pkg::DIV_STEPS+1];

  logic [rmq_pkg::DW-1:0] lane_q [rmq_pkg::LANES];
  logic [rmq_pkg::DW-1:0] root_q;
  logic [rmq_pkg::DW-1:0] qw_nxt, qx_nxt, qy_nxt, qz_nxt;
  logic [rmq_pkg::DW-1:0] qw_r, qx_r, qy_r, qz_r;
  logic [1:0]             sel_r;
  logic                   valid_r, degen_r;

  assign busy = 1'b0;

  rmq_front u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (start),
    .c0r0 (in_c0r0),
    .c0r1 (in_c0r1),
    .c0r2 (in_c0r2),
    .c1r0 (in_c1r0),
    .c1r1 (in_c1r1),
    .c1r2 (in_c1r2),
    .c2r0 (in_c2r0),
    .c2r1 (in_c2r1),
    .c2r2 (in_c2r2),
    .q    (sq[0])
  );

  for (genvar g = 0; g < rmq_pkg::SQ_STEPS; g++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .d    (sq[g]),
      .q    (sq[g+1])
    );
  end

  always_comb begin
    dv[0].ctl  = sq[rmq_pkg::SQ_STEPS].ctl;
    dv[0].root = sq[rmq_pkg::SQ_STEPS].root;
    dv[0].neg  = sq[rmq_pkg::SQ_STEPS].neg;
    for (int k = 0; k < rmq_pkg::LANES; k++) begin
      dv[0].num[k] = {sq[rmq_pkg::SQ_STEPS].mag[k], rmq_pkg::FRAC_SH'(0)};
      dv[0].rem[k] = '0;
    end
  end

  for (genvar g = 0; g < rmq_pkg::DIV_STEPS; g++) begin : g_div
    rmq_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .d    (dv[g]),
      .q    (dv[g+1])
    );
  end

  always_comb begin
    root_q = {1'b0, dv[rmq_pkg::DIV_STEPS].root};
    for (int k = 0; k < rmq_pkg::LANES; k++) begin
      if (dv[rmq_pkg::DIV_STEPS].neg[k]) begin
        lane_q[k] = (dv[rmq_pkg::DIV_STEPS].num[k] > rmq_pkg::NUM_W'(32768))
                  ? 16'h8000
                  : rmq_pkg::DW'(~dv[rmq_pkg::DIV_STEPS].num[k] + 1'b1);
      end else begin
        lane_q[k] = (dv[rmq_pkg::DIV_STEPS].num[k] > rmq_pkg::NUM_W'(32767))
                  ? 16'h7fff
                  : rmq_pkg::DW'(dv[rmq_pkg::DIV_STEPS].num[k]);
      end
    end
    unique case (dv[rmq_pkg::DIV_STEPS].ctl.sel)
      rmq_pkg::SEL_W: begin
        qw_nxt = root_q;    qx_nxt = lane_q[0];
        qy_nxt = lane_q[1]; qz_nxt = lane_q[2];
      end
      rmq_pkg::SEL_X: begin
        qw_nxt = lane_q[0]; qx_nxt = root_q;
        qy_nxt = lane_q[1]; qz_nxt = lane_q[2];
      end
      rmq_pkg::SEL_Y: begin
        qw_nxt = lane_q[0]; qx_nxt = lane_q[1];
        qy_nxt = root_q;    qz_nxt = lane_q[2];
      end
      default: begin
        qw_nxt = lane_q[0]; qx_nxt = lane_q[1];
        qy_nxt = lane_q[2]; qz_nxt = root_q;
      end
    endcase
    if (dv[rmq_pkg::DIV_STEPS].ctl.degen) begin
      qw_nxt = '0;
      qx_nxt = '0;
      qy_nxt = '0;
      qz_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= dv[rmq_pkg::DIV_STEPS].ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    qw_r    <= qw_nxt;
    qx_r    <= qx_nxt;
    qy_r    <= qy_nxt;
    qz_r    <= qz_nxt;
    sel_r   <= dv[rmq_pkg::DIV_STEPS].ctl.sel;
    degen_r <= dv[rmq_pkg::DIV_STEPS].ctl.degen;
  end

  assign out_valid       = valid_r;
  assign out_qw          = qw_r;
  assign out_qx          = qx_r;
  assign out_qy          = qy_r;
  assign out_qz          = qz_r;
  assign out_largest_sel = sel_r;
  assign out_degenerate  = degen_r;

endmodule

`default_nettype wire

FILE: design/rmq_checker.sv
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks on the matrix to quaternion block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rotation_matrix_to_quaternion_macros.svh"

module rmq_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          out_valid,
  input wire logic signed [rmq_pkg::DW-1:0] out_qw,
  input wire logic signed [rmq_pkg::DW-1:0] out_qx,
  input wire logic signed [rmq_pkg::DW-1:0] out_qy,
  input wire logic signed [rmq_pkg::DW-1:0] out_qz,
  input wire logic [1:0]                    out_largest_sel,
  input wire logic                          out_degenerate
);

  `RMQ_ASSERT_NOW(a_never_busy, 1'b1, !busy)
  `RMQ_ASSERT_NOW(a_result_has_request, out_valid, $past(start, rmq_pkg::LATENCY))
  `RMQ_ASSERT_NOW(a_degen_zero, out_valid && out_degenerate, (out_qw == 0) && (out_qx == 0) && (out_qy == 0) && (out_qz == 0) && (out_largest_sel == rmq_pkg::SEL_W))
  `RMQ_ASSERT_NOW(a_root_positive, out_valid && !out_degenerate, ((out_largest_sel != rmq_pkg::SEL_W) || (out_qw >= 64)) && ((out_largest_sel != rmq_pkg::SEL_X) || (out_qx >= 64)) && ((out_largest_sel != rmq_pkg::SEL_Y) || (out_qy >= 64)) && ((out_largest_sel != rmq_pkg::SEL_Z) || (out_qz >= 64)))

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);

`default_nettype wire
